>>> hw/rtl/bamop_pkg.sv
// -----------------------------------------------------------------------------
// bamop_pkg
// Shared types, constants and helpers of the binomial American option pricer.
// -----------------------------------------------------------------------------
package bamop_pkg;

   // price words are unsigned Q16.16
   localparam int PRICE_W       = 32;
   localparam int MAX_STEPS_DEF = 256;
   localparam int DIVIDEND_W    = 64;
   localparam int DIVISOR_W     = 32;

   localparam logic [63:0] ONE_Q30 = 64'd1 << 30;
   localparam logic [63:0] LIM39   = (64'd1 << 39) - 64'd1;
   localparam logic [63:0] LIM40   = 64'd1 << 40;

   // configuration register indexes
   typedef enum logic [2:0] {
      CSR_NUM_STEPS       = 3'd0,
      CSR_UP_FACTOR       = 3'd1,
      CSR_DOWN_FACTOR     = 3'd2,
      CSR_UP_PROBABILITY  = 3'd3,
      CSR_DISCOUNT_FACTOR = 3'd4,
      CSR_THETA_SCALE     = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [31:0] spot_price;
      logic [31:0] strike_price;
      logic        option_kind;
   } req_type;

   typedef struct packed {
      logic               status;
      logic [31:0]        option_price;
      logic signed [31:0] delta;
      logic signed [39:0] gamma;
      logic signed [39:0] theta;
   } rsp_type;

   // command from the sequencer to the divider
   typedef struct packed {
      logic                  start;
      logic [DIVIDEND_W-1:0] dividend;
      logic [DIVISOR_W-1:0]  divisor;
   } div_req_type;

   // exercise value of a call or a put
   function automatic logic [PRICE_W-1:0] payoff(input logic [PRICE_W-1:0] stock,
                                                 input logic [PRICE_W-1:0] strike,
                                                 input logic               put);
      logic [PRICE_W-1:0] v;
      v = '0;
      if (put) begin
         if (strike > stock) v = strike - stock;
      end else begin
         if (stock > strike) v = stock - strike;
      end
      return v;
   endfunction

endpackage

>>> hw/rtl/binomial_american_option_pricer.sv
// -----------------------------------------------------------------------------
// binomial_american_option_pricer
// American option pricer on a Cox-Ross-Rubinstein lattice with greeks.
// -----------------------------------------------------------------------------
// One request at a time: req_stall stays high from acceptance until the result
// is loaded into the response register. The lattice sweep needs three passes
// through the single shared multiplier per node, and the four greek divisions
// run in the bit-serial divider. A zero spot or strike returns status 1 with
// zero results.
// -----------------------------------------------------------------------------
module binomial_american_option_pricer
   import bamop_pkg::*;
#(
   parameter int MAX_STEPS = MAX_STEPS_DEF
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   localparam int NW = $clog2(MAX_STEPS + 1);
   localparam int LW = $clog2(2 * MAX_STEPS + 1);

   localparam logic [1:0] G_DELTA = 2'd0;
   localparam logic [1:0] G_DUP   = 2'd1;
   localparam logic [1:0] G_DDN   = 2'd2;
   localparam logic [1:0] G_GAMMA = 2'd3;

   typedef enum logic [17:0] {
      S_IDLE    = 18'b000000000000000001,
      S_LAD_UP  = 18'b000000000000000010,
      S_LAD_DN  = 18'b000000000000000100,
      S_LAD_WD  = 18'b000000000000001000,
      S_LEAF_RD = 18'b000000000000010000,
      S_LEAF_WR = 18'b000000000000100000,
      S_NRD0    = 18'b000000000001000000,
      S_NLD0    = 18'b000000000010000000,
      S_NRD     = 18'b000000000100000000,
      S_NM1     = 18'b000000001000000000,
      S_NM2     = 18'b000000010000000000,
      S_NM3     = 18'b000000100000000000,
      S_NWR     = 18'b000001000000000000,
      S_G_START = 18'b000010000000000000,
      S_G_WAIT  = 18'b000100000000000000,
      S_THETA   = 18'b001000000000000000,
      S_THETA2  = 18'b010000000000000000,
      S_DONE    = 18'b100000000000000000
   } state_type;

   // configuration registers
   logic [8:0]  num_steps_ff;
   logic [31:0] up_factor_ff;
   logic [29:0] down_factor_ff;
   logic [30:0] up_prob_ff;
   logic [30:0] discount_ff;
   logic [31:0] theta_scale_ff;

   // control
   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   // payload
   logic [PRICE_W-1:0] spot_ff, spot_in, strike_ff, strike_in;
   logic               put_ff, put_in, err_ff, err_in;
   logic [NW-1:0]      n_ff, n_in, k_ff, k_in, j_ff, j_in, s_ff, s_in;
   logic [30:0]        p_ff, p_in, q_ff, q_in, disc_ff, disc_in;
   logic [PRICE_W-1:0] lad_up_ff, lad_up_in, lad_dn_ff, lad_dn_in;
   logic [PRICE_W-1:0] s1u_ff, s1u_in, s1d_ff, s1d_in, s2uu_ff, s2uu_in, s2dd_ff, s2dd_in;
   logic [PRICE_W-1:0] vdn_ff, vdn_in, vup_ff, vup_in, ex_ff, ex_in, acc_ff, acc_in;
   logic [PRICE_W-1:0] root_ff, root_in;
   logic [PRICE_W-1:0] s1_ff [2];
   logic [PRICE_W-1:0] s1_in [2];
   logic [PRICE_W-1:0] s2_ff [3];
   logic [PRICE_W-1:0] s2_in [3];
   logic [1:0]         g_idx_ff, g_idx_in;
   logic signed [41:0] delta_ff, delta_in, dup_ff, dup_in, ddn_ff, ddn_in;
   logic signed [41:0] gamma_ff, gamma_in;
   logic signed [39:0] theta_ff, theta_in;
   rsp_type            rsp_ff, rsp_in;

   // memories
   logic [PRICE_W-1:0] lad_mem  [2 * MAX_STEPS + 1];
   logic [PRICE_W-1:0] node_mem [MAX_STEPS + 1];
   logic               lad_we, node_we;
   logic [LW-1:0]      lad_waddr, lad_raddr;
   logic [NW-1:0]      node_waddr, node_raddr;
   logic [PRICE_W-1:0] lad_wdata, node_wdata, lad_rd_ff, node_rd_ff;

   // shared units
   logic [31:0]        mul_a, mul_f;
   logic [63:0]        mul_prod;
   logic [PRICE_W-1:0] mul_rnd;
   div_req_type        div_req;
   logic               div_done;
   logic [63:0]        div_quo;

   // combinational helpers
   logic               accept;
   logic               rsp_free;
   logic [31:0]        n_clamp;
   logic [30:0]        p_clamp;
   logic [LW:0]        lad_addr_wide;
   logic [NW-1:0]      s_sel;
   logic [PRICE_W:0]   blend_sum;
   logic [PRICE_W-1:0] blend, node_new;
   logic signed [42:0] g_num;
   logic signed [32:0] g_den;
   logic [42:0]        g_mag;
   logic               g_den_ok;
   logic [63:0]        g_lim, g_qsat;
   logic signed [41:0] g_val;
   logic signed [32:0] t_diff;
   logic [31:0]        t_mag;
   logic [47:0]        t_q;
   logic [39:0]        t_sat;

   bamop_mul u_mul (
      .clock    (clock),
      .mul_a    (mul_a),
      .mul_f    (mul_f),
      .mul_prod (mul_prod),
      .mul_rnd  (mul_rnd)
   );

   bamop_div u_div (
      .clock    (clock),
      .reset    (reset),
      .div_req  (div_req),
      .div_done (div_done),
      .div_quo  (div_quo)
   );

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         num_steps_ff   <= 9'd3;
         up_factor_ff   <= 32'd1073741825;
         down_factor_ff <= 30'd1073741823;
         up_prob_ff     <= 31'd536870912;
         discount_ff    <= 31'd1073741824;
         theta_scale_ff <= 32'd65536;
      end else if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_NUM_STEPS:       num_steps_ff   <= csr_wdata[8:0];
            CSR_UP_FACTOR:       up_factor_ff   <= csr_wdata;
            CSR_DOWN_FACTOR:     down_factor_ff <= csr_wdata[29:0];
            CSR_UP_PROBABILITY:  up_prob_ff     <= csr_wdata[30:0];
            CSR_DISCOUNT_FACTOR: discount_ff    <= csr_wdata[30:0];
            CSR_THETA_SCALE:     theta_scale_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign accept    = req_valid && (state_ff == S_IDLE);
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   // clamp step count and probabilities at acceptance
   always_comb begin
      n_clamp = 32'(num_steps_ff);
      if (n_clamp < 32'd3) n_clamp = 32'd3;
      if (n_clamp > 32'(MAX_STEPS)) n_clamp = 32'(MAX_STEPS);
      p_clamp = (64'(up_prob_ff) > ONE_Q30) ? 31'(ONE_Q30) : up_prob_ff;
   end

   // ladder address of node j at step s: center - s + 2j
   always_comb begin
      s_sel         = state_ff == S_LEAF_RD ? n_ff : s_ff;
      lad_addr_wide = (LW + 1)'(MAX_STEPS) - (LW + 1)'(s_sel) + ((LW + 1)'(j_ff) << 1);
      lad_raddr     = lad_addr_wide[LW-1:0];
      node_raddr    = (state_ff == S_NRD0) ? '0 : NW'(j_ff + 1'b1);
   end

   // hold value and node update
   always_comb begin
      blend_sum = {1'b0, acc_ff} + {1'b0, mul_rnd};
      blend     = blend_sum[PRICE_W] ? '1 : blend_sum[PRICE_W-1:0];
      node_new  = (ex_ff > mul_rnd) ? ex_ff : mul_rnd;
   end

   // shared multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_f = '0;
      unique case (1'b1)
         state_ff[1]:  begin mul_a = 32'(lad_up_ff); mul_f = up_factor_ff;       end
         state_ff[2]:  begin mul_a = 32'(lad_dn_ff); mul_f = 32'(down_factor_ff); end
         state_ff[9]:  begin mul_a = 32'(node_rd_ff); mul_f = 32'(p_ff);         end
         state_ff[10]: begin mul_a = 32'(vdn_ff);    mul_f = 32'(q_ff);          end
         state_ff[11]: begin mul_a = 32'(blend);     mul_f = 32'(disc_ff);       end
         state_ff[15]: begin mul_a = t_mag;          mul_f = theta_scale_ff;     end
         default: ;
      endcase
   end

   // finite difference operands for the greek in progress
   always_comb begin
      g_num = '0;
      g_den = '0;
      g_lim = LIM40;
      unique case (g_idx_ff)
         G_DELTA: begin
            g_num = 43'($signed({1'b0, s1_ff[1]})) - 43'($signed({1'b0, s1_ff[0]}));
            g_den = $signed({1'b0, s1u_ff}) - $signed({1'b0, s1d_ff});
            g_lim = ONE_Q30;
         end
         G_DUP: begin
            g_num = 43'($signed({1'b0, s2_ff[2]})) - 43'($signed({1'b0, s2_ff[1]}));
            g_den = $signed({1'b0, s2uu_ff}) - $signed({1'b0, spot_ff});
         end
         G_DDN: begin
            g_num = 43'($signed({1'b0, s2_ff[1]})) - 43'($signed({1'b0, s2_ff[0]}));
            g_den = $signed({1'b0, spot_ff}) - $signed({1'b0, s2dd_ff});
         end
         G_GAMMA: begin
            g_num = 43'(dup_ff) - 43'(ddn_ff);
            g_den = $signed({1'b0, s2uu_ff}) - $signed({1'b0, s2dd_ff});
            g_lim = LIM39;
         end
         default: ;
      endcase
      g_mag    = g_num[42] ? 43'(-g_num) : 43'(g_num);
      g_den_ok = !g_den[32] && (g_den != '0);
      g_qsat   = (div_quo > g_lim) ? g_lim : div_quo;
      g_val    = 42'(g_qsat);
      if (g_num[42]) g_val = -g_val;
      div_req.start    = (state_ff == S_G_START) && g_den_ok;
      div_req.dividend = (g_idx_ff == G_GAMMA) ? (64'(g_mag) << 11) : (64'(g_mag) << 30);
      div_req.divisor  = g_den[31:0];
   end

   // theta magnitude and scaled product
   always_comb begin
      t_diff = $signed({1'b0, s2_ff[1]}) - $signed({1'b0, root_ff});
      t_mag  = t_diff[32] ? 32'(-t_diff) : t_diff[31:0];
      t_q    = mul_prod[63:16];
      t_sat  = (t_q > 48'(LIM39)) ? 40'(LIM39) : t_q[39:0];
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      spot_in = spot_ff;  strike_in = strike_ff;  put_in = put_ff;  err_in = err_ff;
      n_in = n_ff;  k_in = k_ff;  j_in = j_ff;  s_in = s_ff;
      p_in = p_ff;  q_in = q_ff;  disc_in = disc_ff;
      lad_up_in = lad_up_ff;  lad_dn_in = lad_dn_ff;
      s1u_in = s1u_ff;  s1d_in = s1d_ff;  s2uu_in = s2uu_ff;  s2dd_in = s2dd_ff;
      vdn_in = vdn_ff;  vup_in = vup_ff;  ex_in = ex_ff;  acc_in = acc_ff;
      root_in = root_ff;
      s1_in = s1_ff;
      s2_in = s2_ff;
      g_idx_in = g_idx_ff;
      delta_in = delta_ff;  dup_in = dup_ff;  ddn_in = ddn_ff;  gamma_in = gamma_ff;
      theta_in = theta_ff;
      rsp_in   = rsp_ff;
      lad_we = 1'b0;  lad_waddr = LW'(MAX_STEPS);  lad_wdata = spot_ff;
      node_we = 1'b0;  node_waddr = j_ff;  node_wdata = node_new;

      // drop the response once taken
      if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               spot_in   = req_data.spot_price;
               strike_in = req_data.strike_price;
               put_in    = req_data.option_kind;
               n_in      = NW'(n_clamp);
               p_in      = p_clamp;
               q_in      = 31'(ONE_Q30) - p_clamp;
               disc_in   = (64'(discount_ff) > ONE_Q30) ? 31'(ONE_Q30) : discount_ff;
               lad_up_in = req_data.spot_price;
               lad_dn_in = req_data.spot_price;
               k_in      = NW'(1);
               if (req_data.spot_price == '0 || req_data.strike_price == '0) begin
                  err_in   = 1'b1;
                  state_in = S_DONE;
               end else begin
                  err_in    = 1'b0;
                  lad_we    = 1'b1;
                  lad_wdata = req_data.spot_price;
                  state_in  = S_LAD_UP;
               end
            end
         end
         S_LAD_UP: state_in = S_LAD_DN;
         S_LAD_DN: begin
            // up rung ready
            lad_we    = 1'b1;
            lad_waddr = LW'(MAX_STEPS) + LW'(k_ff);
            lad_wdata = mul_rnd;
            lad_up_in = mul_rnd;
            if (k_ff == NW'(1)) s1u_in = mul_rnd;
            if (k_ff == NW'(2)) s2uu_in = mul_rnd;
            state_in  = S_LAD_WD;
         end
         S_LAD_WD: begin
            // down rung ready
            lad_we    = 1'b1;
            lad_waddr = LW'(MAX_STEPS) - LW'(k_ff);
            lad_wdata = mul_rnd;
            lad_dn_in = mul_rnd;
            if (k_ff == NW'(1)) s1d_in = mul_rnd;
            if (k_ff == NW'(2)) s2dd_in = mul_rnd;
            if (k_ff == n_ff) begin
               j_in     = '0;
               state_in = S_LEAF_RD;
            end else begin
               k_in     = k_ff + 1'b1;
               state_in = S_LAD_UP;
            end
         end
         S_LEAF_RD: state_in = S_LEAF_WR;
         S_LEAF_WR: begin
            node_we    = 1'b1;
            node_wdata = payoff(lad_rd_ff, strike_ff, put_ff);
            if (j_ff == n_ff) begin
               s_in     = n_ff - 1'b1;
               j_in     = '0;
               state_in = S_NRD0;
            end else begin
               j_in     = j_ff + 1'b1;
               state_in = S_LEAF_RD;
            end
         end
         S_NRD0: state_in = S_NLD0;
         S_NLD0: begin
            vdn_in   = node_rd_ff;
            state_in = S_NRD;
         end
         S_NRD: state_in = S_NM1;
         S_NM1: begin
            vup_in   = node_rd_ff;
            ex_in    = payoff(lad_rd_ff, strike_ff, put_ff);
            state_in = S_NM2;
         end
         S_NM2: begin
            acc_in   = mul_rnd;
            state_in = S_NM3;
         end
         S_NM3: state_in = S_NWR;
         S_NWR: begin
            node_we = 1'b1;
            vdn_in  = vup_ff;
            if (s_ff == NW'(2)) s2_in[j_ff[1:0]] = node_new;
            if (s_ff == NW'(1)) s1_in[j_ff[0]] = node_new;
            if (j_ff == s_ff) begin
               j_in = '0;
               if (s_ff == '0) begin
                  root_in  = node_new;
                  g_idx_in = G_DELTA;
                  state_in = S_G_START;
               end else begin
                  s_in     = s_ff - 1'b1;
                  state_in = S_NRD0;
               end
            end else begin
               j_in     = j_ff + 1'b1;
               state_in = S_NRD;
            end
         end
         S_G_START, S_G_WAIT: begin
            // a non-positive spread gives zero without dividing
            if ((state_ff == S_G_WAIT && div_done) ||
                (state_ff == S_G_START && !g_den_ok)) begin
               unique case (g_idx_ff)
                  G_DELTA: delta_in = g_den_ok ? g_val : '0;
                  G_DUP:   dup_in   = g_den_ok ? g_val : '0;
                  G_DDN:   ddn_in   = g_den_ok ? g_val : '0;
                  G_GAMMA: gamma_in = g_den_ok ? g_val : '0;
                  default: ;
               endcase
               if (g_idx_ff == G_GAMMA) begin
                  state_in = S_THETA;
               end else begin
                  g_idx_in = g_idx_ff + 1'b1;
                  state_in = S_G_START;
               end
            end else if (state_ff == S_G_START) begin
               state_in = S_G_WAIT;
            end
         end
         S_THETA: state_in = S_THETA2;
         S_THETA2: begin
            theta_in = t_diff[32] ? -$signed(t_sat) : $signed(t_sat);
            state_in = S_DONE;
         end
         S_DONE: begin
            if (rsp_free) begin
               rsp_in.status       = err_ff;
               rsp_in.option_price = err_ff ? '0 : root_ff;
               rsp_in.delta        = err_ff ? '0 : delta_ff[31:0];
               rsp_in.gamma        = err_ff ? '0 : gamma_ff[39:0];
               rsp_in.theta        = err_ff ? '0 : theta_ff;
               rsp_valid_in        = 1'b1;
               state_in            = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      spot_ff <= spot_in;  strike_ff <= strike_in;  put_ff <= put_in;  err_ff <= err_in;
      n_ff <= n_in;  k_ff <= k_in;  j_ff <= j_in;  s_ff <= s_in;
      p_ff <= p_in;  q_ff <= q_in;  disc_ff <= disc_in;
      lad_up_ff <= lad_up_in;  lad_dn_ff <= lad_dn_in;
      s1u_ff <= s1u_in;  s1d_ff <= s1d_in;  s2uu_ff <= s2uu_in;  s2dd_ff <= s2dd_in;
      vdn_ff <= vdn_in;  vup_ff <= vup_in;  ex_ff <= ex_in;  acc_ff <= acc_in;
      root_ff <= root_in;
      s1_ff <= s1_in;
      s2_ff <= s2_in;
      g_idx_ff <= g_idx_in;
      delta_ff <= delta_in;  dup_ff <= dup_in;  ddn_ff <= ddn_in;  gamma_ff <= gamma_in;
      theta_ff <= theta_in;
      rsp_ff   <= rsp_in;
   end

   // price ladder store
   always_ff @(posedge clock) begin
      if (lad_we) lad_mem[lad_waddr] <= lad_wdata;
      lad_rd_ff <= lad_mem[lad_raddr];
   end

   // node value store
   always_ff @(posedge clock) begin
      if (node_we) node_mem[node_waddr] <= node_wdata;
      node_rd_ff <= node_mem[node_raddr];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

>>> hw/rtl/bamop_mul.sv
// -----------------------------------------------------------------------------
// bamop_mul
// Shared 32x32 multiplier with a registered product, rounded Q30 view.
// -----------------------------------------------------------------------------
module bamop_mul
   import bamop_pkg::*;
(
   input  logic               clock,
   input  logic [31:0]        mul_a,
   input  logic [31:0]        mul_f,
   output logic [63:0]        mul_prod,
   output logic [PRICE_W-1:0] mul_rnd
);

   logic [63:0] prod_ff;
   logic [64:0] rsum;
   logic [34:0] rq;

   // register the raw product
   always_ff @(posedge clock) begin
      prod_ff <= 64'(mul_a) * 64'(mul_f);
   end

   // round half up at Q30, saturate to the price width
   always_comb begin
      rsum     = {1'b0, prod_ff} + (65'd1 << 29);
      rq       = rsum[64:30];
      mul_rnd  = (rq[34:PRICE_W] != '0) ? '1 : rq[PRICE_W-1:0];
      mul_prod = prod_ff;
   end

endmodule

>>> hw/rtl/bamop_div.sv
// -----------------------------------------------------------------------------
// bamop_div
// Restoring divider, one quotient bit per cycle, unsigned.
// -----------------------------------------------------------------------------
module bamop_div
   import bamop_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  div_req_type           div_req,
   output logic                  div_done,
   output logic [DIVIDEND_W-1:0] div_quo
);

   localparam int CW = $clog2(DIVIDEND_W);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVISOR_W-1:0]  dvs_ff, dvs_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DIVISOR_W:0]    trial;

   // shift in one dividend bit, subtract when it fits
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      quo_in  = quo_ff;
      trial   = {rem_ff, quo_ff[DIVIDEND_W-1]};
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         dvs_in  = div_req.divisor;
         quo_in  = div_req.dividend;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = DIVISOR_W'(trial - {1'b0, dvs_ff});
            quo_in = {quo_ff[DIVIDEND_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DIVISOR_W-1:0];
            quo_in = {quo_ff[DIVIDEND_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CW'(DIVIDEND_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      quo_ff <= quo_in;
   end

   assign div_done = done_ff;
   assign div_quo  = quo_ff;

endmodule

>>> hw/rtl/bamop_chk.sv
// -----------------------------------------------------------------------------
// bamop_chk
// Port-level checks of the option pricer, bound to the top level.
// -----------------------------------------------------------------------------
module bamop_chk
   import bamop_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input req_type     req_data,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input rsp_type     rsp_data,
   input logic        csr_wr_en,
   input logic [2:0]  csr_index,
   input logic [31:0] csr_wdata
);

   // hold a stalled response
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("response dropped while stalled");

   // stall after every accepted request
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second request taken while busy");

   // error responses carry zero results
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status |->
         rsp_data.option_price == '0 && rsp_data.delta == '0 &&
         rsp_data.gamma == '0 && rsp_data.theta == '0)
      else $error("error response with nonzero results");

   // delta stays within plus or minus one
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         rsp_data.delta <= 32'sd1073741824 && rsp_data.delta >= -32'sd1073741824)
      else $error("delta out of range");

endmodule

bind binomial_american_option_pricer bamop_chk u_bamop_chk (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data),
   .csr_wr_en (csr_wr_en),
   .csr_index (csr_index),
   .csr_wdata (csr_wdata)
);

>>> dv/tb_binomial_american_option_pricer.sv
// -----------------------------------------------------------------------------
// tb_binomial_american_option_pricer
// Self-checking bench for the binomial American option pricer. Each accepted
// request is priced by an in-bench lattice predictor (price, delta, gamma and
// theta) and queued; each response is compared field by field with the oldest
// queued entry. Lattice settings are changed only while the pricer is idle.
// -----------------------------------------------------------------------------
module tb_binomial_american_option_pricer;
   import bamop_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int LADDER_MID  = 256;
   localparam int STALL_LIMIT = 1000000;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_stall;
   rsp_type     rsp_data;
   logic        csr_wr_en;
   logic [2:0]  csr_index;
   logic [31:0] csr_wdata;

   // lattice settings as the pricer holds them
   logic [8:0]  cfg_steps;
   logic [31:0] cfg_up;
   logic [29:0] cfg_down;
   logic [30:0] cfg_prob;
   logic [30:0] cfg_disc;
   logic [31:0] cfg_theta;

   logic [63:0] stock_ladder [0:2*LADDER_MID];
   logic [63:0] lattice [0:LADDER_MID];

   rsp_type     expected_quotes [$];
   int          error_count;
   int          quiet_cycles;
   int          stall_left;
   bit          idling_on;

   binomial_american_option_pricer dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #6 clock = ~clock;

   // ---------------------------------------------------------------- predictor
   function automatic logic [63:0] clip_price(input logic [63:0] v);
      return (v > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : v;
   endfunction

   // rounded price * Q2.30 factor
   function automatic logic [63:0] scale_q30(input logic [63:0] a, input logic [63:0] f);
      logic [63:0] hi;
      logic [63:0] lo;
      hi = (a >> 24) * f;
      lo = (a & 64'hFF_FFFF) * f;
      return clip_price((hi >> 6) + ((((hi & 64'd63) << 24) + lo + (64'd1 << 29)) >> 30));
   endfunction

   function automatic logic [63:0] exercise_value(input logic [63:0] stock,
                                                  input logic [63:0] strike, input bit put);
      if (put) return (strike > stock) ? strike - stock : 64'd0;
      return (stock > strike) ? stock - strike : 64'd0;
   endfunction

   // floor(n * 2^shift / d), limited
   function automatic logic [63:0] shifted_quotient(input logic [63:0] n, input logic [63:0] d,
                                                    input int shift, input logic [63:0] lim);
      logic [63:0] q;
      logic [63:0] r;
      q = n / d;
      r = n % d;
      if (q > lim) return lim;
      for (int i = 0; i < shift; i++) begin
         q = q << 1;
         r = r << 1;
         if (r >= d) begin
            r = r - d;
            q = q + 1;
         end
         if (q > lim) return lim;
      end
      return q;
   endfunction

   // signed finite difference; zero for a non-positive spread
   function automatic longint slope(input longint num, input longint den, input int shift,
                                    input logic [63:0] lim);
      logic [63:0] mag;
      logic [63:0] q;
      if (den <= 0) return 0;
      mag = (num < 0) ? -num : num;
      q = shifted_quotient(mag, den, shift, lim);
      return (num < 0) ? -longint'(q) : longint'(q);
   endfunction

   function automatic rsp_type price_option(input req_type r);
      rsp_type     o;
      logic [63:0] spot, strike, n, p, q, disc, ex, blend, hold, mag, tmag, hi, lo;
      logic [63:0] one_step [0:1];
      logic [63:0] two_step [0:2];
      longint      dlt, d_up, d_dn, gam, th, diff;
      bit          put;
      o = '0;
      spot   = 64'(r.spot_price);
      strike = 64'(r.strike_price);
      put    = r.option_kind;
      if (spot == 0 || strike == 0) begin
         o.status = 1'b1;
         return o;
      end
      n    = (cfg_steps < 3) ? 3 : ((cfg_steps > 256) ? 256 : cfg_steps);
      p    = (cfg_prob > ONE_Q30) ? ONE_Q30 : cfg_prob;
      q    = ONE_Q30 - p;
      disc = (cfg_disc > ONE_Q30) ? ONE_Q30 : cfg_disc;
      one_step = '{default: 0};
      two_step = '{default: 0};

      // build the stock ladder around spot
      stock_ladder[LADDER_MID] = spot;
      for (int k = 1; k <= n; k++) begin
         stock_ladder[LADDER_MID + k] = scale_q30(stock_ladder[LADDER_MID + k - 1], cfg_up);
         stock_ladder[LADDER_MID - k] = scale_q30(stock_ladder[LADDER_MID - k + 1], cfg_down);
      end
      for (int j = 0; j <= n; j++)
         lattice[j] = exercise_value(stock_ladder[LADDER_MID + 2*j - int'(n)], strike, put);

      // backward induction with early exercise
      for (int st = int'(n) - 1; st >= 0; st--) begin
         for (int j = 0; j <= st; j++) begin
            ex    = exercise_value(stock_ladder[LADDER_MID + 2*j - st], strike, put);
            blend = clip_price(scale_q30(lattice[j+1], p) + scale_q30(lattice[j], q));
            hold  = scale_q30(blend, disc);
            lattice[j] = (ex > hold) ? ex : hold;
         end
         if (st == 2) for (int j = 0; j < 3; j++) two_step[j] = lattice[j];
         if (st == 1) for (int j = 0; j < 2; j++) one_step[j] = lattice[j];
      end

      dlt  = slope(longint'(one_step[1]) - longint'(one_step[0]),
                   longint'(stock_ladder[LADDER_MID+1]) - longint'(stock_ladder[LADDER_MID-1]),
                   30, ONE_Q30);
      d_up = slope(longint'(two_step[2]) - longint'(two_step[1]),
                   longint'(stock_ladder[LADDER_MID+2]) - longint'(spot), 30, LIM40);
      d_dn = slope(longint'(two_step[1]) - longint'(two_step[0]),
                   longint'(spot) - longint'(stock_ladder[LADDER_MID-2]), 30, LIM40);
      gam  = slope(d_up - d_dn,
                   longint'(stock_ladder[LADDER_MID+2]) - longint'(stock_ladder[LADDER_MID-2]),
                   11, LIM39);

      // theta: truncated product, limited to 39 bits of magnitude
      diff = longint'(two_step[1]) - longint'(lattice[0]);
      mag  = (diff < 0) ? -diff : diff;
      hi   = (mag >> 24) * cfg_theta;
      lo   = ((mag & 64'hFF_FFFF) * cfg_theta) >> 16;
      if (hi > (LIM39 >> 8)) tmag = LIM39;
      else if ((hi << 8) + lo > LIM39) tmag = LIM39;
      else tmag = (hi << 8) + lo;
      th = (diff < 0) ? -longint'(tmag) : longint'(tmag);

      o.status       = 1'b0;
      o.option_price = 32'(clip_price(lattice[0]));
      o.delta        = dlt[31:0];
      o.gamma        = gam[39:0];
      o.theta        = th[39:0];
      return o;
   endfunction

   // ---------------------------------------------------------------- checking
   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   // compare each accepted response with the oldest priced request
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_quotes.size() == 0) begin
            report_mismatch("unexpected response", 64'(rsp_data.option_price), 64'd0);
         end else begin
            want = expected_quotes.pop_front();
            if (rsp_data.status !== want.status)
               report_mismatch("status", 64'(rsp_data.status), 64'(want.status));
            if (rsp_data.option_price !== want.option_price)
               report_mismatch("option_price", 64'(rsp_data.option_price),
                               64'(want.option_price));
            if (rsp_data.delta !== want.delta)
               report_mismatch("delta", 64'(rsp_data.delta), 64'(want.delta));
            if (rsp_data.gamma !== want.gamma)
               report_mismatch("gamma", 64'(rsp_data.gamma), 64'(want.gamma));
            if (rsp_data.theta !== want.theta)
               report_mismatch("theta", 64'(rsp_data.theta), 64'(want.theta));
         end
      end
   end

   // stall the response side in short random bursts
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_stall = 1'b1;
      end else if (idling_on && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(0, 3);
         rsp_stall  = 1'b1;
      end else begin
         rsp_stall = 1'b0;
      end
   end

   // end the run if nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAIL");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------- drivers
   task automatic write_reg(input csr_index_type idx, input logic [31:0] value);
      @(negedge clock);
      csr_wr_en = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      @(posedge clock);
      case (idx)
         CSR_NUM_STEPS:       cfg_steps = value[8:0];
         CSR_UP_FACTOR:       cfg_up    = value;
         CSR_DOWN_FACTOR:     cfg_down  = value[29:0];
         CSR_UP_PROBABILITY:  cfg_prob  = value[30:0];
         CSR_DISCOUNT_FACTOR: cfg_disc  = value[30:0];
         CSR_THETA_SCALE:     cfg_theta = value;
         default: ;
      endcase
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   task automatic set_lattice(input logic [31:0] steps, input logic [31:0] up,
                              input logic [31:0] down, input logic [31:0] prob,
                              input logic [31:0] disc, input logic [31:0] theta);
      write_reg(CSR_NUM_STEPS, steps);
      write_reg(CSR_UP_FACTOR, up);
      write_reg(CSR_DOWN_FACTOR, down);
      write_reg(CSR_UP_PROBABILITY, prob);
      write_reg(CSR_DISCOUNT_FACTOR, disc);
      write_reg(CSR_THETA_SCALE, theta);
   endtask

   // hold the request until accepted, then price it
   task automatic send_request(input logic [31:0] spot, input logic [31:0] strike,
                               input bit put);
      req_type r;
      int      gap;
      r.spot_price   = spot;
      r.strike_price = strike;
      r.option_kind  = put;
      gap = (idling_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
      repeat (gap) begin
         @(negedge clock);
         req_valid = 1'b0;
      end
      @(negedge clock);
      req_valid = 1'b1;
      req_data  = r;
      do @(posedge clock); while (req_stall);
      expected_quotes.push_back(price_option(r));
   endtask

   // drop valid and wait for every priced request to come back
   task automatic drain();
      @(negedge clock);
      req_valid = 1'b0;
      while (expected_quotes.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // mostly realistic requests with strike within half of spot either way, else random or zero inputs
   task automatic send_random_request();
      logic [31:0] spot;
      int          pick;
      pick = $urandom_range(0, 9);
      spot = $urandom_range(32'h0001_0000, 32'h0400_0000);
      if (pick < 8)
         send_request(spot, 32'((64'(spot) * $urandom_range(50, 150)) / 100),
                      $urandom_range(0, 1));
      else if (pick == 8)
         send_request($urandom, $urandom, $urandom_range(0, 1));
      else if ($urandom_range(0, 1))
         send_request(0, $urandom, $urandom_range(0, 1));
      else
         send_request($urandom, 0, $urandom_range(0, 1));
   endtask

   task automatic pick_random_lattice();
      logic [31:0] up;
      up = 32'h4000_0000 + $urandom_range(32'h0004_0000, 32'h0400_0000);
      set_lattice($urandom_range(3, 16), up, 32'((64'd1 << 60) / up),
                  $urandom_range(32'h1C00_0000, 32'h2400_0000),
                  32'h4000_0000 - $urandom_range(0, 32'h0010_0000), $urandom);
   endtask

   // ---------------------------------------------------------------- tests
   task automatic test_reset_settings();
      send_request(32'h0064_0000, 32'h0064_0000, 1'b0);
      send_request(32'h0064_0000, 32'h0064_0000, 1'b1);
      send_request(32'hFFFF_FFFF, 32'h0000_0001, 1'b0);
      send_request(32'h0000_0001, 32'hFFFF_FFFF, 1'b1);
      send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
      send_request(32'h0000_0001, 32'h0000_0001, 1'b0);
      drain();
   endtask

   task automatic test_zero_inputs();
      send_request(0, 32'h0064_0000, 1'b0);
      send_request(32'h0064_0000, 0, 1'b1);
      send_request(0, 0, 1'b0);
      send_request(0, 32'hFFFF_FFFF, 1'b1);
      drain();
   endtask

   task automatic test_extreme_factors();
      // steps below three clamp; probability and discount above one act as one
      set_lattice(0, 32'hFFFF_FFFF, 1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
      send_request(32'h0001_0000, 32'h0002_0000, 1'b0);
      send_request(32'h0001_0000, 32'h0002_0000, 1'b1);
      send_request(32'hFFFF_FFFF, 32'h8000_0000, 1'b0);
      drain();
      // zero probability and zero discount: payoff dominates everywhere
      set_lattice(3, 32'h4000_0001, 32'h3FFF_FFFF, 0, 0, 0);
      send_request(32'h0064_0000, 32'h0050_0000, 1'b0);
      send_request(32'h0064_0000, 32'h0078_0000, 1'b1);
      send_request(32'h0064_0000, 32'h0064_0000, 1'b1);
      drain();
   endtask

   task automatic test_full_depth();
      // nine-bit step count above the maximum clamps to the full lattice
      set_lattice(32'h1FF, 32'h4066_0000, 32'h3F9A_7000, 32'h2000_0000, 32'h3FFF_F000,
                  32'h0010_0000);
      send_request(32'h0064_0000, 32'h0069_0000, 1'b1);
      send_request(32'h0064_0000, 32'h005F_0000, 1'b0);
      drain();
   endtask

   task automatic test_random_lattices();
      for (int phase = 0; phase < 3; phase++) begin
         pick_random_lattice();
         idling_on = (phase < 2);
         for (int i = 0; i < 28; i++) send_random_request();
         drain();
      end
   endtask

   initial begin
      clock       = 1'b0;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_data    = '0;
      rsp_stall   = 1'b0;
      csr_wr_en   = 1'b0;
      csr_index   = CSR_NUM_STEPS;
      csr_wdata   = '0;
      error_count = 0;
      quiet_cycles = 0;
      stall_left  = 0;
      idling_on   = 1'b1;
      cfg_steps   = 9'd3;
      cfg_up      = 32'd1073741825;
      cfg_down    = 30'd1073741823;
      cfg_prob    = 31'd536870912;
      cfg_disc    = 31'd1073741824;
      cfg_theta   = 32'd65536;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_settings();
      test_zero_inputs();
      test_extreme_factors();
      test_full_depth();
      test_random_lattices();

      if (error_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
